// File: rtl/owbm_pkg.sv
// owbm_pkg: shared types and constants of the one-wire bus master.
// Used by one_wire_bus_master; depends on nothing.
package owbm_pkg;

	localparam int unsigned RECOVERY_TICKS = 2;
	localparam int unsigned BITS_PER_BYTE  = 8;

	localparam int unsigned REQ_W  = 3;
	localparam int unsigned LONG_W = 10;
	localparam int unsigned SHORT_W = 8;
	localparam int unsigned CFG_W  = 10;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 16;

	// request codes, also used as the running operation kind
	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RESET = 3'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RBYTE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RBIT  = 3'd4;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_RESET_LOW   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_RESET_WAIT  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_PRES_WINDOW = 3'd2;
	localparam logic [IDX_W-1:0] CFG_PRES_TAIL   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_SLOT        = 3'd4;
	localparam logic [IDX_W-1:0] CFG_W1_LOW      = 3'd5;
	localparam logic [IDX_W-1:0] CFG_READ_LOW    = 3'd6;
	localparam logic [IDX_W-1:0] CFG_READ_SAMPLE = 3'd7;

	// register reset values
	localparam logic [LONG_W-1:0]  RST_RESET_LOW   = 10'd480;
	localparam logic [LONG_W-1:0]  RST_RESET_WAIT  = 10'd60;
	localparam logic [LONG_W-1:0]  RST_PRES_WINDOW = 10'd240;
	localparam logic [LONG_W-1:0]  RST_PRES_TAIL   = 10'd180;
	localparam logic [SHORT_W-1:0] RST_SLOT        = 8'd60;
	localparam logic [SHORT_W-1:0] RST_W1_LOW      = 8'd6;
	localparam logic [SHORT_W-1:0] RST_READ_LOW    = 8'd6;
	localparam logic [SHORT_W-1:0] RST_READ_SAMPLE = 8'd9;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RLOW  = 3'd1,
		PH_RWAIT = 3'd2,
		PH_RWIN  = 3'd3,
		PH_RTAIL = 3'd4,
		PH_SLOT  = 3'd5
	} phase_t;

endpackage

// File: rtl/one_wire_bus_master.sv
// one_wire_bus_master: open-drain single-wire bus master stepped once per tick beat.
// Depends on owbm_pkg for codes, register indexes and reset values.

// Every input beat is one bus tick: it carries the sampled line level and
// may start a reset, a byte write, a byte read or a bit read (ignored while
// busy). One beat is taken per clock cycle; its result beat appears in the
// output register on the next cycle, and a stall on the output side holds
// the input only while that register is full and not taken. Result bits:
// drive_low, busy, done, presence of the last reset, and the value read,
// which is nonzero only on the done beat of a read.
module one_wire_bus_master (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [owbm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // write_value, line_level, zero pad
	input  logic [owbm_pkg::REQ_W-1:0]          s_axis_tuser,  // req_type
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [owbm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // drive_low, busy_res, done_res,
	                                                           // device_present, read_value, zero pad
	input  logic                                cfg_we,
	input  logic [owbm_pkg::IDX_W-1:0]          cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int unsigned LW = owbm_pkg::LONG_W;
	localparam int unsigned SW = owbm_pkg::SHORT_W;

	// configuration
	logic [LW-1:0] reset_low_q, reset_wait_q, pres_window_q, pres_tail_q;
	logic [SW-1:0] slot_q, w1_low_q, read_low_q, read_sample_q;

	// bus state
	owbm_pkg::phase_t          phase_q;
	logic [owbm_pkg::REQ_W-1:0] op_q;
	logic [LW-1:0]             tc_q;
	logic [2:0]                bi_q;
	logic [7:0]                sh_q;
	logic                      pres_q;

	// output register
	logic                      out_v_q;
	logic [owbm_pkg::OUT_DATA_W-1:0] out_d_q;

	logic                      accept;
	logic [owbm_pkg::REQ_W-1:0] req;
	logic [7:0]                wval;
	logic                      line;

	// values after the start decision
	owbm_pkg::phase_t          ph_e;
	logic [owbm_pkg::REQ_W-1:0] op_e;
	logic [LW-1:0]             tc_e;
	logic [2:0]                bi_e;
	logic [7:0]                sh_e;
	logic                      pr_e;

	// next state
	owbm_pkg::phase_t          ph_n;
	logic [owbm_pkg::REQ_W-1:0] op_n;
	logic [LW-1:0]             tc_n;
	logic [2:0]                bi_n;
	logic [7:0]                sh_n;
	logic                      pr_n;
	logic                      finish;

	logic [LW:0]               tc1;
	logic [LW:0]               len;
	logic [SW:0]               read_at;
	logic [LW-1:0]             slot_base;
	logic [SW-1:0]             wlow;

	// result
	logic                      drive, busy, done;
	logic [7:0]                rval;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_v_q || m_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;

	assign req  = s_axis_tuser;
	assign wval = s_axis_tdata[7:0];
	assign line = s_axis_tdata[8];

	assign read_at = {1'b0, read_low_q} + {1'b0, read_sample_q};
	assign wlow    = (w1_low_q < slot_q) ? w1_low_q : slot_q;

	// next state
	always_comb begin
		ph_e = phase_q;
		op_e = op_q;
		tc_e = tc_q;
		bi_e = bi_q;
		sh_e = sh_q;
		pr_e = pres_q;
		if (phase_q == owbm_pkg::PH_IDLE && req >= owbm_pkg::REQ_RESET
				&& req <= owbm_pkg::REQ_RBIT) begin
			op_e = req;
			tc_e = '0;
			bi_e = '0;
			if (req == owbm_pkg::REQ_RESET) begin
				pr_e = 1'b0;
				ph_e = owbm_pkg::PH_RLOW;
			end else begin
				ph_e = owbm_pkg::PH_SLOT;
				sh_e = (req == owbm_pkg::REQ_WRITE) ? wval : 8'd0;
			end
		end

		ph_n = ph_e;
		op_n = op_e;
		tc_n = tc_e;
		bi_n = bi_e;
		sh_n = sh_e;
		pr_n = pr_e;
		finish = 1'b0;

		if (ph_e == owbm_pkg::PH_RWIN && !line)
			pr_n = 1'b1;
		if (ph_e == owbm_pkg::PH_SLOT && op_e != owbm_pkg::REQ_WRITE
				&& tc_e == {1'b0, read_at})
			sh_n[bi_e] = line;

		if ((op_e != owbm_pkg::REQ_WRITE) && ({1'b0, read_at} + 10'd1 > {2'b0, slot_q}))
			slot_base = {1'b0, read_at} + 10'd1;
		else
			slot_base = {2'b0, slot_q};

		case (ph_e)
			owbm_pkg::PH_RLOW:  len = (reset_low_q == '0) ? 11'd1 : {1'b0, reset_low_q};
			owbm_pkg::PH_RWAIT: len = {1'b0, reset_wait_q};
			owbm_pkg::PH_RWIN:  len = {1'b0, pres_window_q};
			owbm_pkg::PH_RTAIL: len = {1'b0, pres_tail_q};
			owbm_pkg::PH_SLOT:  len = {1'b0, slot_base} + 11'(owbm_pkg::RECOVERY_TICKS);
			default:            len = '0;
		endcase

		tc1 = {1'b0, tc_e} + 11'd1;

		if (ph_e != owbm_pkg::PH_IDLE) begin
			if (tc1 < len) begin
				tc_n = tc1[LW-1:0];
			end else begin
				case (ph_e)
					owbm_pkg::PH_RLOW: begin
						tc_n = '0;
						if (reset_wait_q != '0)       ph_n = owbm_pkg::PH_RWAIT;
						else if (pres_window_q != '0) ph_n = owbm_pkg::PH_RWIN;
						else if (pres_tail_q != '0)   ph_n = owbm_pkg::PH_RTAIL;
						else                          finish = 1'b1;
					end
					owbm_pkg::PH_RWAIT: begin
						tc_n = '0;
						if (pres_window_q != '0)      ph_n = owbm_pkg::PH_RWIN;
						else if (pres_tail_q != '0)   ph_n = owbm_pkg::PH_RTAIL;
						else                          finish = 1'b1;
					end
					owbm_pkg::PH_RWIN: begin
						tc_n = '0;
						if (pres_tail_q != '0)        ph_n = owbm_pkg::PH_RTAIL;
						else                          finish = 1'b1;
					end
					owbm_pkg::PH_SLOT: begin
						if (op_e != owbm_pkg::REQ_RBIT
								&& bi_e < 3'(owbm_pkg::BITS_PER_BYTE - 1)) begin
							bi_n = bi_e + 3'd1;
							tc_n = '0;
						end else begin
							finish = 1'b1;
						end
					end
					default: finish = 1'b1;
				endcase
			end
			if (finish) begin
				ph_n = owbm_pkg::PH_IDLE;
				op_n = owbm_pkg::REQ_TICK;
				tc_n = '0;
				bi_n = '0;
			end
		end
	end

	// result fields
	always_comb begin
		busy = (ph_e != owbm_pkg::PH_IDLE);
		done = finish;
		drive = 1'b0;
		case (ph_e)
			owbm_pkg::PH_RLOW: drive = 1'b1;
			owbm_pkg::PH_SLOT: begin
				if (op_e == owbm_pkg::REQ_WRITE)
					drive = tc_e < (sh_e[bi_e] ? {2'b0, wlow} : {2'b0, slot_q});
				else
					drive = tc_e < {2'b0, read_low_q};
			end
			default: drive = 1'b0;
		endcase
		rval = 8'd0;
		if (finish && op_e == owbm_pkg::REQ_RBYTE)
			rval = sh_n;
		else if (finish && op_e == owbm_pkg::REQ_RBIT)
			rval = {7'd0, sh_n[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q   <= owbm_pkg::RST_RESET_LOW;
			reset_wait_q  <= owbm_pkg::RST_RESET_WAIT;
			pres_window_q <= owbm_pkg::RST_PRES_WINDOW;
			pres_tail_q   <= owbm_pkg::RST_PRES_TAIL;
			slot_q        <= owbm_pkg::RST_SLOT;
			w1_low_q      <= owbm_pkg::RST_W1_LOW;
			read_low_q    <= owbm_pkg::RST_READ_LOW;
			read_sample_q <= owbm_pkg::RST_READ_SAMPLE;
		end else if (cfg_we) begin
			case (cfg_index)
				owbm_pkg::CFG_RESET_LOW:   reset_low_q   <= cfg_data;
				owbm_pkg::CFG_RESET_WAIT:  reset_wait_q  <= cfg_data;
				owbm_pkg::CFG_PRES_WINDOW: pres_window_q <= cfg_data;
				owbm_pkg::CFG_PRES_TAIL:   pres_tail_q   <= cfg_data;
				owbm_pkg::CFG_SLOT:        slot_q        <= cfg_data[SW-1:0];
				owbm_pkg::CFG_W1_LOW:      w1_low_q      <= cfg_data[SW-1:0];
				owbm_pkg::CFG_READ_LOW:    read_low_q    <= cfg_data[SW-1:0];
				owbm_pkg::CFG_READ_SAMPLE: read_sample_q <= cfg_data[SW-1:0];
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owbm_pkg::PH_IDLE;
			op_q    <= owbm_pkg::REQ_TICK;
			tc_q    <= '0;
			bi_q    <= '0;
			sh_q    <= '0;
			pres_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_n;
			op_q    <= op_n;
			tc_q    <= tc_n;
			bi_q    <= bi_n;
			sh_q    <= sh_n;
			pres_q  <= pr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_v_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_d_q <= {4'd0, rval, pr_n, done, busy, drive};
	end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for one_wire_bus_master; every beat is one bus tick.
// Depends on owbm_pkg and the RTL only; predicts each result beat and checks it
// field by field, across register settings and random sender/receiver idling.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;

	typedef struct packed {
		logic       drive;
		logic       busy;
		logic       done;
		logic       present;
		logic [7:0] rval;
	} tick_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // write_value, line_level, zero pad
	logic [REQ_W-1:0]       s_axis_tuser = REQ_TICK;  // req_type
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;        // drive_low, busy, done, present, read_value
	logic                   cfg_we = 1'b0;
	logic [IDX_W-1:0]       cfg_index = CFG_RESET_LOW;
	logic [CFG_W-1:0]       cfg_data = '0;

	// bus master state as predicted
	logic [CFG_W-1:0]       cfg_reg [8];
	phase_t                 bm_phase = PH_IDLE;
	logic [REQ_W-1:0]       bm_op = REQ_TICK;
	logic [LONG_W-1:0]      bm_count = '0;
	logic [2:0]             bm_bit = '0;
	logic [7:0]             bm_shift = '0;
	logic                   bm_present = 1'b0;

	tick_result_t           expected_ticks [$];
	int                     src_idle_pct = 0;
	int                     snk_stall_pct = 0;
	int                     line_low_pct = 50;
	int                     ticks_sent = 0;
	int                     mismatches = 0;

	one_wire_bus_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int sample_at();
		return int'(cfg_reg[CFG_READ_LOW]) + int'(cfg_reg[CFG_READ_SAMPLE]);
	endfunction

	function automatic int write_low_len();
		int slot;
		slot = int'(cfg_reg[CFG_SLOT]);
		if (!bm_shift[bm_bit])
			return slot;
		return (int'(cfg_reg[CFG_W1_LOW]) < slot) ? int'(cfg_reg[CFG_W1_LOW]) : slot;
	endfunction

	function automatic int stage_len(phase_t ph);
		int n;
		case (ph)
		PH_RLOW:  return (cfg_reg[CFG_RESET_LOW] == 0) ? 1 : int'(cfg_reg[CFG_RESET_LOW]);
		PH_RWAIT: return int'(cfg_reg[CFG_RESET_WAIT]);
		PH_RWIN:  return int'(cfg_reg[CFG_PRES_WINDOW]);
		PH_RTAIL: return int'(cfg_reg[CFG_PRES_TAIL]);
		PH_SLOT: begin
			n = int'(cfg_reg[CFG_SLOT]);
			if (bm_op != REQ_WRITE && sample_at() + 1 > n)
				n = sample_at() + 1;
			return n + RECOVERY_TICKS;
		end
		default: return 0;
		endcase
	endfunction

	// advances the predicted master by one tick and returns that tick's result
	function automatic tick_result_t predict_tick(logic [2:0] req, logic [7:0] wv, logic lvl);
		tick_result_t r;
		int tc;
		int nxt;
		logic ends;
		r = '0;
		ends = 1'b0;
		if (bm_phase == PH_IDLE && req >= REQ_RESET && req <= REQ_RBIT) begin
			bm_op = req;
			bm_count = '0;
			bm_bit = '0;
			if (req == REQ_RESET) begin
				bm_present = 1'b0;
				bm_phase = PH_RLOW;
			end else begin
				bm_phase = PH_SLOT;
				bm_shift = (req == REQ_WRITE) ? wv : 8'h00;
			end
		end
		if (bm_phase != PH_IDLE) begin
			r.busy = 1'b1;
			tc = int'(bm_count);
			if (bm_phase == PH_RLOW) begin
				r.drive = 1'b1;
			end else if (bm_phase == PH_RWIN) begin
				if (!lvl)
					bm_present = 1'b1;
			end else if (bm_phase == PH_SLOT) begin
				if (bm_op == REQ_WRITE) begin
					r.drive = (tc < write_low_len());
				end else begin
					r.drive = (tc < int'(cfg_reg[CFG_READ_LOW]));
					if (tc == sample_at())
						bm_shift[bm_bit] = lvl;
				end
			end
			tc++;
			if (tc < stage_len(bm_phase)) begin
				bm_count = tc[LONG_W-1:0];
			end else if (bm_phase >= PH_RLOW && bm_phase < PH_RTAIL) begin
				nxt = int'(bm_phase) + 1;
				while (nxt <= int'(PH_RTAIL) && stage_len(phase_t'(nxt)) == 0)
					nxt++;
				if (nxt > int'(PH_RTAIL)) begin
					ends = 1'b1;
				end else begin
					bm_phase = phase_t'(nxt);
					bm_count = '0;
				end
			end else if (bm_phase == PH_SLOT && bm_op != REQ_RBIT &&
			             int'(bm_bit) < BITS_PER_BYTE - 1) begin
				bm_bit++;
				bm_count = '0;
			end else begin
				ends = 1'b1;
			end
			if (ends) begin
				r.done = 1'b1;
				if (bm_op == REQ_RBYTE)
					r.rval = bm_shift;
				else if (bm_op == REQ_RBIT)
					r.rval = {7'd0, bm_shift[0]};
				bm_phase = PH_IDLE;
				bm_op = REQ_TICK;
				bm_count = '0;
				bm_bit = '0;
			end
		end
		r.present = bm_present;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
	                               input logic [7:0] want);
		mismatches++;
		$display("mismatch %s at %0t: got %h, expected %h", what, $realtime, got, want);
	endtask

	always @(posedge clk) begin : check_beats
		tick_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata[7:0], 8'h00);
			end else begin
				want = expected_ticks.pop_front();
				if (m_axis_tdata[0] !== want.drive)
					report_mismatch("drive_low", 8'(m_axis_tdata[0]), 8'(want.drive));
				if (m_axis_tdata[1] !== want.busy)
					report_mismatch("busy_res", 8'(m_axis_tdata[1]), 8'(want.busy));
				if (m_axis_tdata[2] !== want.done)
					report_mismatch("done_res", 8'(m_axis_tdata[2]), 8'(want.done));
				if (m_axis_tdata[3] !== want.present)
					report_mismatch("device_present", 8'(m_axis_tdata[3]),
					                8'(want.present));
				if (m_axis_tdata[11:4] !== want.rval)
					report_mismatch("read_value", m_axis_tdata[11:4], want.rval);
			end
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

	function automatic logic line_sample();
		return ($urandom_range(99) >= line_low_pct);
	endfunction

	task automatic set_idling(input int src, input int snk);
		src_idle_pct = src;
		snk_stall_pct = snk;
	endtask

	task automatic send_tick(input logic [2:0] req, input logic [7:0] wv, input logic lvl);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {7'd0, lvl, wv};
		do @(posedge clk); while (!s_axis_tready);
		expected_ticks.push_back(predict_tick(req, wv, lvl));
		ticks_sent++;
	endtask

	// ticks until the running command is over, with stray requests that must be ignored
	task automatic finish_command();
		while (bm_phase != PH_IDLE)
			send_tick(3'($urandom_range(7)), 8'($urandom), line_sample());
	endtask

	task automatic run_command(input logic [2:0] cmd, input logic [7:0] wv);
		send_tick(cmd, wv, line_sample());
		finish_command();
	endtask

	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_regs(input int unsigned r0, input int unsigned r1,
	                            input int unsigned r2, input int unsigned r3,
	                            input int unsigned r4, input int unsigned r5,
	                            input int unsigned r6, input int unsigned r7);
		logic [CFG_W-1:0] vals [8];
		vals[0] = CFG_W'(r0);
		vals[1] = CFG_W'(r1);
		vals[2] = CFG_W'(r2);
		vals[3] = CFG_W'(r3);
		vals[4] = CFG_W'(r4);
		vals[5] = CFG_W'(r5);
		vals[6] = CFG_W'(r6);
		vals[7] = CFG_W'(r7);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			cfg_reg[i] = (i >= int'(CFG_SLOT)) ? {2'b00, vals[i][7:0]} : vals[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_default_timing();
		set_idling(13, 13);
		line_low_pct = 50;
		run_command(REQ_RBIT, 8'h00);
	endtask

	task automatic test_presence_and_codes();
		quiesce();
		set_idling(47, 0);
		program_regs(8, 3, 6, 4, 6, 3, 2, 4);
		line_low_pct = 0;
		run_command(REQ_RESET, 8'h00);
		line_low_pct = 100;
		run_command(REQ_RESET, 8'h00);
		line_low_pct = 0;
		run_command(REQ_WRITE, 8'h3C);
		send_tick(3'd5, 8'hFF, 1'b1);
		send_tick(3'd6, 8'h00, 1'b0);
		send_tick(3'd7, 8'h81, 1'b1);
		send_tick(REQ_TICK, 8'h7E, 1'b0);
		// a write starts, and the stray commands after it land on a busy master
		line_low_pct = 50;
		send_tick(REQ_WRITE, 8'h55, 1'b1);
		send_tick(REQ_RESET, 8'h00, 1'b0);
		send_tick(REQ_RBYTE, 8'h00, 1'b1);
		send_tick(REQ_RBIT, 8'h00, 1'b0);
		finish_command();
	endtask

	task automatic test_zero_lengths();
		quiesce();
		set_idling(0, 47);
		program_regs(0, 0, 0, 0, 0, 0, 0, 0);
		line_low_pct = 50;
		run_command(REQ_RESET, 8'h00);
		run_command(REQ_WRITE, 8'hFF);
		run_command(REQ_WRITE, 8'h00);
		run_command(REQ_RBYTE, 8'h00);
		run_command(REQ_RBIT, 8'h00);
	endtask

	task automatic test_long_lengths();
		quiesce();
		set_idling(0, 0);
		// 8-bit registers keep their low byte; the read sample lands past 255
		program_regs(4, 0, 1, 0, 258, 257, 130, 126);
		line_low_pct = 50;
		run_command(REQ_RESET, 8'h00);
		run_command(REQ_WRITE, 8'h5A);
		run_command(REQ_RBIT, 8'h00);
	endtask

	task automatic test_slot_corners();
		quiesce();
		set_idling(13, 13);
		// write-one low time longer than the slot
		program_regs(4, 1, 2, 1, 5, 20, 1, 1);
		run_command(REQ_WRITE, 8'hF0);
		quiesce();
		// read sample past the slot end stretches the slot
		program_regs(4, 1, 2, 1, 2, 5, 1, 2);
		line_low_pct = 50;
		run_command(REQ_RBYTE, 8'h00);
		run_command(REQ_RBIT, 8'h00);
		quiesce();
		program_regs(4, 1, 2, 1, 2, 1, 1, 0);
		run_command(REQ_RBYTE, 8'h00);
	endtask

	task automatic test_change_mid_command();
		quiesce();
		set_idling(47, 47);
		line_low_pct = 50;
		program_regs(30, 2, 3, 2, 20, 4, 3, 3);
		repeat (12) send_tick(REQ_RESET, 8'h00, line_sample());
		quiesce();
		program_regs(5, 2, 3, 2, 20, 4, 3, 3);
		finish_command();
		repeat (9) send_tick(REQ_WRITE, 8'h00, line_sample());
		quiesce();
		program_regs(5, 2, 3, 2, 6, 4, 3, 3);
		finish_command();
		quiesce();
		program_regs(5, 2, 3, 2, 4, 4, 3, 10);
		repeat (6) send_tick(REQ_RBIT, 8'h00, line_sample());
		quiesce();
		program_regs(5, 2, 3, 2, 4, 4, 3, 1);
		finish_command();
	endtask

	task automatic test_random_traffic();
		int start;
		int lows [5];
		lows = '{0, 5, 50, 95, 100};
		for (int ph = 0; ph < 4; ph++) begin
			quiesce();
			case (ph)
			0: set_idling(0, 0);
			1: set_idling(47, 0);
			2: set_idling(0, 47);
			default: set_idling(13, 13);
			endcase
			program_regs($urandom_range(12), $urandom_range(6), $urandom_range(8),
			             $urandom_range(6), $urandom_range(12), $urandom_range(14),
			             $urandom_range(8), $urandom_range(12));
			start = ticks_sent;
			while (ticks_sent - start < 20) begin
				line_low_pct = lows[$urandom_range(4)];
				if ($urandom_range(99) < 80)
					run_command(3'($urandom_range(1, 4)), 8'($urandom));
				else
					repeat ($urandom_range(1, 4))
						send_tick(3'($urandom_range(7)), 8'($urandom), line_sample());
			end
			finish_command();
		end
	endtask

	initial begin
		cfg_reg[CFG_RESET_LOW]   = RST_RESET_LOW;
		cfg_reg[CFG_RESET_WAIT]  = RST_RESET_WAIT;
		cfg_reg[CFG_PRES_WINDOW] = RST_PRES_WINDOW;
		cfg_reg[CFG_PRES_TAIL]   = RST_PRES_TAIL;
		cfg_reg[CFG_SLOT]        = {2'b00, RST_SLOT};
		cfg_reg[CFG_W1_LOW]      = {2'b00, RST_W1_LOW};
		cfg_reg[CFG_READ_LOW]    = {2'b00, RST_READ_LOW};
		cfg_reg[CFG_READ_SAMPLE] = {2'b00, RST_READ_SAMPLE};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_timing();
		test_presence_and_codes();
		test_zero_lengths();
		test_long_lengths();
		test_slot_corners();
		test_change_mid_command();
		test_random_traffic();

		quiesce();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/owbm_pkg.sv
rtl/one_wire_bus_master.sv
tb/sv/tb_top.sv
